// ----- src/jedq_pkg.sv -----
// ----------------------------------------------------------------------------
// jedq_pkg: shared types and constants
// Register codes, quantizer command values, reset values of the setup
// registers and the reciprocal used to divide the scaled knob value by 67.
// ----------------------------------------------------------------------------
package jedq_pkg;

  localparam int unsigned RAW_W = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 12;
  localparam int unsigned CMD_W = 5;
  localparam int unsigned POS_W = 16;
  localparam int unsigned CENTER_W = 10;
  localparam int unsigned TOL_W = 9;
  localparam int unsigned SHIFT_W = 3;
  localparam int unsigned STEP_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CENTER = 3'd0,
    REG_TOL    = 3'd1,
    REG_SSHIFT = 3'd2,
    REG_KSHIFT = 3'd3,
    REG_KSTEP  = 3'd4
  } cfg_reg_e;

  localparam logic [CENTER_W-1:0] CENTER_RST = 10'd512;
  localparam logic [TOL_W-1:0] TOL_RST = 9'd64;
  localparam logic [SHIFT_W-1:0] SHIFT_RST = 3'd2;
  localparam logic [STEP_W-1:0] STEP_RST = 12'd1;

  localparam logic signed [CMD_W-1:0] CMD_POS_FULL = 5'sd10;
  localparam logic signed [CMD_W-1:0] CMD_POS_HALF = 5'sd8;
  localparam logic signed [CMD_W-1:0] CMD_ZERO = 5'sd0;
  localparam logic signed [CMD_W-1:0] CMD_NEG_FULL = -5'sd10;
  localparam logic signed [CMD_W-1:0] CMD_NEG_X = -5'sd7;
  localparam logic signed [CMD_W-1:0] CMD_NEG_Y = -5'sd8;

  // floor(p / 67) == (p * KNOB_RECIP) >> RECIP_SHIFT for every p below 2^26.
  localparam int unsigned RECIP_SHIFT = 36;
  localparam int unsigned RECIP_W = 30;
  localparam logic [RECIP_W-1:0] KNOB_RECIP = 30'd1025663832;

  typedef struct packed {
    logic               upd;
    logic               load;
    logic [SHIFT_W-1:0] shift;
  } lane_ctrl_t;

  typedef struct packed {
    logic [CENTER_W-1:0] center;
    logic [TOL_W-1:0]    tol;
  } quant_cfg_t;

endpackage

// ----- src/jedq_if.sv -----
// ----------------------------------------------------------------------------
// jedq_if: request channels of the joystick smoother
// One channel carries the three ADC reads, the other the three results.
// ----------------------------------------------------------------------------
interface jedq_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] stick_x_raw;
  logic [15:0] stick_y_raw;
  logic [15:0] knob_raw;

  modport source (output valid, output stick_x_raw, output stick_y_raw,
                  output knob_raw, input ready);
  modport sink (input valid, input stick_x_raw, input stick_y_raw,
                input knob_raw, output ready);
endinterface

interface jedq_out_if;
  logic               valid;
  logic               ready;
  logic signed [4:0]  x_command;
  logic signed [4:0]  y_command;
  logic        [15:0] knob_position;

  modport source (output valid, output x_command, output y_command,
                  output knob_position, input ready);
  modport sink (input valid, input x_command, input y_command,
                input knob_position, output ready);
endinterface

// ----- src/joystick_ema_deadband_quantizer.sv -----
// ----------------------------------------------------------------------------
// joystick_ema_deadband_quantizer: smoothed joystick and knob front end
// Three averaging lanes (X, Y, knob) feed a deadband quantizer and a knob
// scaler; the results merge into one output register.
//
//   Channel   Dir  Carries
//   sample_i  in   stick_x_raw, stick_y_raw, knob_raw (16 bit ADC reads)
//   result_o  out  x_command, y_command (5 bit signed), knob_position (16 bit)
//   cfg_*_i   in   setup register writes, index 0..4, no read-back
//
// One request is taken per cycle while sample_i.ready is high; its result
// passes the average register, the quantizer and product register and the
// output register before it is valid.
// The knob path holds one multiplier before the product register and one after it.
// Reset clears the averages, the first-request flag and all stage valid bits;
// setup registers return to their defaults. Each stage holds while the next is
// full, so requests keep flowing into empty stages while a result waits.
// ----------------------------------------------------------------------------
module joystick_ema_deadband_quantizer #(
  parameter int unsigned SAMPLE_BITS = 10
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  jedq_in_if.sink                           sample_i,
  jedq_out_if.source                        result_o,
  input  logic                              cfg_we_i,
  input  logic [jedq_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [jedq_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import jedq_pkg::*;

  localparam int unsigned SB = SAMPLE_BITS;
  localparam int unsigned RAW_SHIFT = RAW_W - SB;

  // Setup registers.
  logic [CENTER_W-1:0] center_q;
  logic [TOL_W-1:0]    tol_q;
  logic [SHIFT_W-1:0]  sshift_q, kshift_q;
  logic [STEP_W-1:0]   kstep_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_q <= CENTER_RST;
      tol_q    <= TOL_RST;
      sshift_q <= SHIFT_RST;
      kshift_q <= SHIFT_RST;
      kstep_q  <= STEP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTER: center_q <= cfg_data_i[CENTER_W-1:0];
        REG_TOL:    tol_q    <= cfg_data_i[TOL_W-1:0];
        REG_SSHIFT: sshift_q <= cfg_data_i[SHIFT_W-1:0];
        REG_KSHIFT: kshift_q <= cfg_data_i[SHIFT_W-1:0];
        REG_KSTEP:  kstep_q  <= cfg_data_i[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control.
  logic vld1_q, vld2_q, vld3_q;
  logic rdy1, rdy2, rdy3;
  logic acc;
  logic primed_q;

  assign rdy3 = !vld3_q || result_o.ready;
  assign rdy2 = !vld2_q || rdy3;
  assign rdy1 = !vld1_q || rdy2;
  assign acc  = sample_i.valid && rdy1;
  assign sample_i.ready = rdy1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld1_q   <= 1'b0;
      vld2_q   <= 1'b0;
      vld3_q   <= 1'b0;
      primed_q <= 1'b0;
    end else begin
      if (rdy1) vld1_q <= acc;
      if (rdy2) vld2_q <= vld1_q;
      if (rdy3) vld3_q <= vld2_q;
      if (acc)  primed_q <= 1'b1;
    end
  end

  // Averaging lanes. The lane registers double as the first pipeline stage:
  // they only change on acceptance, which needs the stage to be free.
  lane_ctrl_t    stick_ctrl, knob_ctrl;
  logic [SB-1:0] sx, sy, sk;
  logic [SB-1:0] x_avg, y_avg, k_avg;

  assign sx = SB'(sample_i.stick_x_raw >> RAW_SHIFT);
  assign sy = SB'(sample_i.stick_y_raw >> RAW_SHIFT);
  assign sk = SB'(sample_i.knob_raw >> RAW_SHIFT);

  always_comb begin
    stick_ctrl.upd   = acc;
    stick_ctrl.load  = !primed_q;
    stick_ctrl.shift = sshift_q;
    knob_ctrl.upd    = acc;
    knob_ctrl.load   = !primed_q;
    knob_ctrl.shift  = kshift_q;
  end

  jedq_ema_lane #(.SB(SB)) u_lane_x (
    .clk_i, .rst_ni, .ctrl_i(stick_ctrl), .sample_i(sx), .avg_o(x_avg)
  );
  jedq_ema_lane #(.SB(SB)) u_lane_y (
    .clk_i, .rst_ni, .ctrl_i(stick_ctrl), .sample_i(sy), .avg_o(y_avg)
  );
  jedq_ema_lane #(.SB(SB)) u_lane_k (
    .clk_i, .rst_ni, .ctrl_i(knob_ctrl), .sample_i(sk), .avg_o(k_avg)
  );

  // Second stage: quantize the sticks, multiply the knob.
  quant_cfg_t               qcfg;
  logic signed [CMD_W-1:0]  xq, yq;
  logic signed [CMD_W-1:0]  x_cmd2_q, y_cmd2_q;
  logic [POS_W-1:0]         kpos;

  assign qcfg.center = center_q;
  assign qcfg.tol    = tol_q;

  jedq_quant #(.SB(SB)) u_quant_x (
    .cfg_i(qcfg), .value_i(x_avg), .low_band_i(CMD_NEG_X), .cmd_o(xq)
  );
  jedq_quant #(.SB(SB)) u_quant_y (
    .cfg_i(qcfg), .value_i(y_avg), .low_band_i(CMD_NEG_Y), .cmd_o(yq)
  );

  jedq_knob_scale #(.SB(SB)) u_knob (
    .clk_i, .en_i(rdy2), .avg_i(k_avg), .step_i(kstep_q), .pos_o(kpos)
  );

  always_ff @(posedge clk_i) begin
    if (rdy2) begin
      x_cmd2_q <= xq;
      y_cmd2_q <= yq;
    end
  end

  // Merge stage: output register.
  logic signed [CMD_W-1:0] x_cmd3_q, y_cmd3_q;
  logic [POS_W-1:0]        kpos3_q;

  always_ff @(posedge clk_i) begin
    if (rdy3) begin
      x_cmd3_q <= x_cmd2_q;
      y_cmd3_q <= y_cmd2_q;
      kpos3_q  <= kpos;
    end
  end

  assign result_o.valid         = vld3_q;
  assign result_o.x_command     = x_cmd3_q;
  assign result_o.y_command     = y_cmd3_q;
  assign result_o.knob_position = kpos3_q;

`ifndef SYNTHESIS
  // Nothing can be in flight before the first request was taken.
  a_no_flight_unprimed: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !primed_q |-> !(vld1_q || vld2_q || vld3_q))
    else $error("stage valid while block never primed");

  // Input is only refused when every stage is occupied.
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !sample_i.ready |-> (vld1_q && vld2_q && vld3_q))
    else $error("input stalled with a free stage");

  // An accepted request reaches the first stage on the next edge.
  a_accept_stage1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc |=> (vld1_q && primed_q))
    else $error("accepted request not in first stage");

  // X commands stay on the legal levels.
  a_x_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld3_q |-> (x_cmd3_q == CMD_POS_FULL || x_cmd3_q == CMD_POS_HALF ||
                x_cmd3_q == CMD_ZERO || x_cmd3_q == CMD_NEG_X ||
                x_cmd3_q == CMD_NEG_FULL))
    else $error("illegal x command level");

  // Y commands stay on the legal levels.
  a_y_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld3_q |-> (y_cmd3_q == CMD_POS_FULL || y_cmd3_q == CMD_POS_HALF ||
                y_cmd3_q == CMD_ZERO || y_cmd3_q == CMD_NEG_Y ||
                y_cmd3_q == CMD_NEG_FULL))
    else $error("illegal y command level");
`endif

endmodule

// ----- src/jedq_ema_lane.sv -----
// ----------------------------------------------------------------------------
// jedq_ema_lane: one smoothing lane
// Holds one running average and updates it with a shift-only moving average,
// or loads the sample directly on the first request after reset.
// ----------------------------------------------------------------------------
module jedq_ema_lane #(
  parameter int unsigned SB = 10
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jedq_pkg::lane_ctrl_t ctrl_i,
  input  logic [SB-1:0]       sample_i,
  output logic [SB-1:0]       avg_o
);
  import jedq_pkg::*;

  localparam int unsigned EW = SB + 8;

  logic [SB-1:0] avg_q, avg_d;
  logic [EW-1:0] scaled;
  logic [EW-1:0] kept;
  logic [SB-1:0] part;

  // avg * (2^a - 1) is formed as (avg << a) - avg.
  always_comb begin
    scaled = (EW'(avg_q) << ctrl_i.shift) - EW'(avg_q);
    kept   = scaled >> ctrl_i.shift;
    part   = sample_i >> ctrl_i.shift;
    avg_d  = ctrl_i.load ? sample_i : (part + kept[SB-1:0]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q <= '0;
    end else if (ctrl_i.upd) begin
      avg_q <= avg_d;
    end
  end

  assign avg_o = avg_q;

endmodule

// ----- src/jedq_quant.sv -----
// ----------------------------------------------------------------------------
// jedq_quant: asymmetric deadband quantizer
// Maps a smoothed stick value onto five command levels around the center.
// ----------------------------------------------------------------------------
module jedq_quant #(
  parameter int unsigned SB = 10
) (
  input  jedq_pkg::quant_cfg_t         cfg_i,
  input  logic [SB-1:0]                value_i,
  input  logic signed [jedq_pkg::CMD_W-1:0] low_band_i,
  output logic signed [jedq_pkg::CMD_W-1:0] cmd_o
);
  import jedq_pkg::*;

  localparam int unsigned QW = ((SB > CENTER_W) ? SB : CENTER_W) + 3;

  logic signed [QW-1:0] v, m, t;
  logic signed [QW-1:0] hi1, hi2, lo1, lo3;

  always_comb begin
    v   = signed'(QW'(value_i));
    m   = signed'(QW'(cfg_i.center));
    t   = signed'(QW'(cfg_i.tol));
    hi1 = m + t;
    hi2 = hi1 + t;
    lo1 = m - t;
    lo3 = lo1 - t - t;
    if (v < hi1 && v > lo1) begin
      cmd_o = CMD_ZERO;
    end else if (v >= hi2) begin
      cmd_o = CMD_POS_FULL;
    end else if (v >= hi1) begin
      cmd_o = CMD_POS_HALF;
    end else if (v <= lo3) begin
      cmd_o = CMD_NEG_FULL;
    end else if (v <= lo1) begin
      cmd_o = low_band_i;
    end else begin
      cmd_o = CMD_ZERO;
    end
  end

endmodule

// ----- src/jedq_knob_scale.sv -----
// ----------------------------------------------------------------------------
// jedq_knob_scale: knob scaling and division by 67
// Registers the product of the knob average and the step, then divides it by
// 67 through a reciprocal multiply, keeping the low 16 bits.
// ----------------------------------------------------------------------------
module jedq_knob_scale #(
  parameter int unsigned SB = 10
) (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [SB-1:0]                 avg_i,
  input  logic [jedq_pkg::STEP_W-1:0]   step_i,
  output logic [jedq_pkg::POS_W-1:0]    pos_o
);
  import jedq_pkg::*;

  localparam int unsigned PW = SB + STEP_W;
  localparam int unsigned FW = (PW + RECIP_W > RECIP_SHIFT + POS_W) ?
                               PW + RECIP_W : RECIP_SHIFT + POS_W;

  logic [PW-1:0] prod_q;
  logic [FW-1:0] full;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= PW'(avg_i) * PW'(step_i);
    end
  end

  always_comb begin
    full  = FW'(prod_q) * FW'(KNOB_RECIP);
    pos_o = full[RECIP_SHIFT +: POS_W];
  end

endmodule
